// ----- rtl/core/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, codes and helpers for the utf-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [20:0] SURROGATE_LO     = 21'h00D800;
    localparam logic [20:0] SURROGATE_HI     = 21'h00DFFF;
    localparam int unsigned PAYLOAD_SHIFT    = 6;

    // byte classes
    localparam logic [2:0] CLS_CONT  = 3'd0;
    localparam logic [2:0] CLS_ASCII = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    // main action of a queued op
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ASCII = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    typedef struct packed {
        logic        has_cut;
        logic [2:0]  cut_len;
        logic [1:0]  kind;
        logic [20:0] value;
        logic [2:0]  len;
    } utf8d_op_t;

    function automatic logic [2:0] byte_class(input logic [7:0] b);
        logic [2:0] cls;
        if (b[7:6] == 2'b10)
            cls = CLS_CONT;
        else if (b[7] == 1'b0)
            cls = CLS_ASCII;
        else if (b[7:5] == 3'b110)
            cls = CLS_LEAD2;
        else if (b[7:4] == 4'b1110)
            cls = CLS_LEAD3;
        else if (b[7:3] == 5'b11110)
            cls = CLS_LEAD4;
        else
            cls = CLS_BAD;
        return cls;
    endfunction

    function automatic logic cp_in_range(input logic [20:0] v, input logic [2:0] len);
        logic [20:0] lo;
        logic [20:0] hi;
        case (len)
            3'd1:
            begin
                lo = 21'h000000;
                hi = 21'h00007F;
            end
            3'd2:
            begin
                lo = 21'h000080;
                hi = 21'h0007FF;
            end
            3'd3:
            begin
                lo = 21'h000800;
                hi = 21'h00FFFF;
            end
            3'd4:
            begin
                lo = 21'h010000;
                hi = 21'h10FFFF;
            end
            default:
            begin
                lo = 21'h000000;
                hi = 21'h10FFFF;
            end
        endcase
        return (v >= lo) && (v <= hi) && !((v >= SURROGATE_LO) && (v <= SURROGATE_HI));
    endfunction

endpackage

// ----- rtl/core/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// utf8d_front
// Classifies each byte, tracks the open sequence and emits one op per byte
// that yields results.
// ----------------------------------------------------------------------------
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  byte_in,
    output logic        push,
    output utf8d_op_t   op
);

    logic [20:0] partial_reg;
    logic [20:0] partial_next;
    logic [2:0]  expected_reg;
    logic [2:0]  expected_next;
    logic [2:0]  seen_reg;
    logic [2:0]  seen_next;

    logic [2:0]  cls;
    logic [20:0] shifted;
    logic [2:0]  seen_inc;
    logic        handled;

    assign cls      = byte_class(byte_in);
    assign shifted  = {partial_reg[20-PAYLOAD_SHIFT:0], byte_in[5:0]};
    assign seen_inc = seen_reg + 3'd1;

    always_comb
    begin
        op            = '0;
        push          = 1'b0;
        handled       = 1'b0;
        partial_next  = partial_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        if (accept)
        begin
            if (expected_reg != 3'd0)
            begin
                if (cls == CLS_CONT)
                begin
                    handled = 1'b1;
                    if (seen_inc >= expected_reg)
                    begin
                        op.kind       = KIND_DONE;
                        op.value      = shifted;
                        op.len        = expected_reg;
                        push          = 1'b1;
                        partial_next  = '0;
                        expected_next = '0;
                        seen_next     = '0;
                    end
                    else
                    begin
                        partial_next = shifted;
                        seen_next    = seen_inc;
                    end
                end
                else
                begin
                    // sequence cut off, the byte is then handled afresh
                    op.has_cut    = 1'b1;
                    op.cut_len    = seen_reg;
                    push          = 1'b1;
                    partial_next  = '0;
                    expected_next = '0;
                    seen_next     = '0;
                end
            end
            if (!handled)
            begin
                case (cls)
                    CLS_ASCII:
                    begin
                        op.kind  = KIND_ASCII;
                        op.value = {13'd0, byte_in};
                        push     = 1'b1;
                    end
                    CLS_CONT, CLS_BAD:
                    begin
                        op.kind = KIND_BAD;
                        push    = 1'b1;
                    end
                    default:
                    begin
                        partial_next  = {13'd0, byte_in & (8'h7F >> cls)};
                        expected_next = cls;
                        seen_next     = 3'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            expected_reg <= '0;
            seen_reg     <= '0;
        end
        else
        begin
            partial_reg  <= partial_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

// ----- rtl/core/utf8d_queue.sv -----
// ----------------------------------------------------------------------------
// utf8d_queue
// Small op queue between the front and back parts.
// ----------------------------------------------------------------------------
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  utf8d_op_t push_op,
    output logic      full,
    input  logic      pop,
    output utf8d_op_t head,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    utf8d_op_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("op pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("op popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

endmodule

// ----- rtl/core/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// utf8d_back
// Turns queued ops into result beats, range-checks finished sequences and
// holds the output register.
// ----------------------------------------------------------------------------
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  utf8d_op_t   head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] code_point,
    output logic [2:0]  bytes_used,
    output logic        valid_res,
    output logic        last
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        cut_done_reg;
    logic        cut_done_next;
    logic [20:0] cp_reg;
    logic [2:0]  used_reg;
    logic        ok_reg;
    logic        last_reg;

    logic        load;
    logic [20:0] cp_next;
    logic [2:0]  used_next;
    logic        ok_next;
    logic        last_next;
    logic        in_range;

    assign load     = !out_valid_reg || !result_stall;
    assign in_range = cp_in_range(head.value, head.len);

    always_comb
    begin
        pop            = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        cut_done_next  = cut_done_reg;
        cp_next        = REPLACEMENT_CHAR;
        used_next      = 3'd1;
        ok_next        = 1'b0;
        last_next      = 1'b1;
        if (load && !empty)
        begin
            out_valid_next = 1'b1;
            if (head.has_cut && !cut_done_reg)
            begin
                // replacement for the cut-off bytes
                used_next = head.cut_len;
                last_next = (head.kind == KIND_NONE);
                if (head.kind == KIND_NONE)
                    pop = 1'b1;
                else
                    cut_done_next = 1'b1;
            end
            else
            begin
                pop           = 1'b1;
                cut_done_next = 1'b0;
                case (head.kind)
                    KIND_ASCII:
                    begin
                        cp_next = head.value;
                        ok_next = 1'b1;
                    end
                    KIND_DONE:
                    begin
                        used_next = head.len;
                        ok_next   = in_range;
                        cp_next   = in_range ? head.value : REPLACEMENT_CHAR;
                    end
                    default:
                    begin
                        cp_next = REPLACEMENT_CHAR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cut_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cut_done_reg  <= cut_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            cp_reg   <= cp_next;
            used_reg <= used_next;
            ok_reg   <= ok_next;
            last_reg <= last_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign code_point   = cp_reg;
    assign bytes_used   = used_reg;
    assign valid_res    = ok_reg;
    assign last         = last_reg;

    a_err_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (cp_reg == REPLACEMENT_CHAR))
        else $error("error beat without replacement char");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((used_reg != 3'd0) && (used_reg <= 3'd4)))
        else $error("bytes_used out of range");

    a_cut_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cut_done_reg |-> (out_valid_reg && !last_reg && !ok_reg))
        else $error("pending second beat after a bad first beat");

endmodule

// ----- rtl/core/utf8_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-at-a-time utf-8 decoder with replacement-char error handling.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full and gives one result
// beat per cycle while result_stall is low. The front tracks the open
// sequence and queues one op per byte that yields anything; the back
// range-checks and drives the output register. A byte that cuts off an open
// sequence and is itself ascii or invalid yields two beats; a queue of
// QUEUE_DEPTH ops absorbs those bursts, and byte_stall rises only while it
// is full. Each op is registered in the queue and then in the output register.
module utf8_stream_decoder_top
    import utf8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_in,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] code_point,
    output logic [2:0]  bytes_used,
    output logic        valid_res,
    output logic        last
);

    logic      accept;
    logic      push;
    utf8d_op_t push_op;
    logic      full;
    logic      pop;
    utf8d_op_t head;
    logic      empty;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    utf8d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (byte_in),
        .push    (push),
        .op      (push_op)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .head    (head),
        .empty   (empty)
    );

    utf8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .bytes_used   (bytes_used),
        .valid_res    (valid_res),
        .last         (last)
    );

endmodule

// ----- tb/utf8_stream_decoder_top_test.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_test
// Self-checking bench for the byte-at-a-time utf-8 decoder. A directed set of
// sequences covers the byte classes and the error cases. Random well-formed
// code points, broken sequences and noise follow under several idle mixes and
// one long output hold-off. Every result beat is checked against a local
// decoder model.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_test;
    import utf8d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 300;
    localparam int LATENCY_SLACK = 8;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  used;
        logic        ok;
        logic        last;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  byte_in;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [20:0] code_point;
    logic [2:0]  bytes_used;
    logic        valid_res;
    logic        last;

    // decoder model state
    logic [20:0] seq_value;
    logic [2:0]  seq_len;
    logic [2:0]  seq_seen;

    decoded_t    pending_decodes[$];
    int          mismatches;
    int          items_sent;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    logic        hold_request;

    utf8_stream_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_in      (byte_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .bytes_used   (bytes_used),
        .valid_res    (valid_res),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    task automatic check_result();
        decoded_t seen;
        decoded_t want;
        seen = '{cp: code_point, used: bytes_used, ok: valid_res, last: last};
        if (pending_decodes.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected beat cp=%h used=%0d ok=%b last=%b",
                seen.cp, seen.used, seen.ok, seen.last));
        end
        else
        begin
            want = pending_decodes.pop_front();
            if (seen.cp !== want.cp || seen.used !== want.used ||
                seen.ok !== want.ok || seen.last !== want.last)
                flag_mismatch($sformatf(
                    "expected cp=%h used=%0d ok=%b last=%b, got cp=%h used=%0d ok=%b last=%b",
                    want.cp, want.used, want.ok, want.last,
                    seen.cp, seen.used, seen.ok, seen.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result();
        result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [2:0] classify_byte(input logic [7:0] b);
        if (b[7:6] == 2'b10)
            return CLS_CONT;
        if (!b[7])
            return CLS_ASCII;
        if (b[7:5] == 3'b110)
            return CLS_LEAD2;
        if (b[7:4] == 4'b1110)
            return CLS_LEAD3;
        if (b[7:3] == 5'b11110)
            return CLS_LEAD4;
        return CLS_BAD;
    endfunction

    // advance the model by one byte and queue the beats it should produce
    task automatic track_utf8_byte(input logic [7:0] b);
        logic [2:0]  cls;
        logic [20:0] lo;
        logic [20:0] hi;
        logic        ok;
        logic        cut;
        logic [2:0]  cut_len;
        cls = classify_byte(b);
        cut = 1'b0;
        cut_len = 3'd0;
        if (seq_len != 3'd0 && cls == CLS_CONT)
        begin
            seq_value = {seq_value[14:0], b[5:0]};
            seq_seen = seq_seen + 3'd1;
            if (seq_seen >= seq_len)
            begin
                case (seq_len)
                    3'd2:
                    begin
                        lo = 21'h000080;
                        hi = 21'h0007FF;
                    end
                    3'd3:
                    begin
                        lo = 21'h000800;
                        hi = 21'h00FFFF;
                    end
                    default:
                    begin
                        lo = 21'h010000;
                        hi = 21'h10FFFF;
                    end
                endcase
                ok = seq_value >= lo && seq_value <= hi &&
                     !(seq_value >= SURROGATE_LO && seq_value <= SURROGATE_HI);
                pending_decodes.push_back('{cp: ok ? seq_value : REPLACEMENT_CHAR,
                    used: seq_len, ok: ok, last: 1'b1});
                seq_value = '0;
                seq_len = '0;
                seq_seen = '0;
            end
        end
        else
        begin
            if (seq_len != 3'd0)
            begin
                // open sequence cut off by this byte
                cut = 1'b1;
                cut_len = seq_seen;
                seq_value = '0;
                seq_len = '0;
                seq_seen = '0;
            end
            if (cls == CLS_ASCII || cls == CLS_CONT || cls == CLS_BAD)
            begin
                if (cut)
                    pending_decodes.push_back('{cp: REPLACEMENT_CHAR, used: cut_len,
                        ok: 1'b0, last: 1'b0});
                if (cls == CLS_ASCII)
                    pending_decodes.push_back('{cp: {14'd0, b[6:0]}, used: 3'd1,
                        ok: 1'b1, last: 1'b1});
                else
                    pending_decodes.push_back('{cp: REPLACEMENT_CHAR, used: 3'd1,
                        ok: 1'b0, last: 1'b1});
            end
            else
            begin
                if (cut)
                    pending_decodes.push_back('{cp: REPLACEMENT_CHAR, used: cut_len,
                        ok: 1'b0, last: 1'b1});
                seq_value = {13'd0, b & (8'h7F >> cls)};
                seq_len = cls;
                seq_seen = 3'd1;
            end
        end
    endtask

    // offer one beat, return at the edge where it was taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_in <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        track_utf8_byte(b);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic send_bytes(input logic [7:0] seq[]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // one random code point sequence, mostly well formed
    task automatic send_random_sequence();
        int          pick;
        int          len;
        int          cut_at;
        logic [20:0] cp;
        logic [7:0]  enc[4];
        pick = $urandom_range(99);
        len = $urandom_range(4, 1);
        case (len)
            1: cp = 21'($urandom_range(21'h00007F, 21'h000000));
            2: cp = 21'($urandom_range(21'h0007FF, 21'h000080));
            3: cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
            default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
        endcase
        // raw payload bits reach overlong, surrogate and too-large values
        if (pick >= 60 && pick < 75)
            cp = 21'($urandom);
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        if (pick >= 90)
        begin
            send_byte(8'($urandom_range(255, 0)));
        end
        else if (pick >= 75 && len > 1)
        begin
            // broken sequence: a prefix, then any byte
            cut_at = $urandom_range(len - 1, 1);
            for (int i = 0; i < cut_at; i++)
                send_byte(enc[i]);
            send_byte(8'($urandom_range(255, 0)));
        end
        else
        begin
            for (int i = 0; i < len; i++)
                send_byte(enc[i]);
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // ascii extremes, stray continuation, invalid byte
        send_bytes('{8'h00, 8'h7F, 8'h80, 8'hFF});
        // max 4-byte value and a value above the code space
        send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
        send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
        // overlong 2-byte form, surrogate
        send_bytes('{8'hC1, 8'hBF});
        send_bytes('{8'hED, 8'hA0, 8'h80});
        // cut by ascii gives two beats
        send_bytes('{8'hE2, 8'h41});
        // cut by a lead that then completes
        send_bytes('{8'hC3, 8'hC2, 8'h80});
        // cut by an invalid byte
        send_bytes('{8'hE0, 8'hA0, 8'hFF});
        wait_for_drain();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = items_sent + count;
        while (items_sent < target)
            send_random_sequence();
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        int target;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        target = items_sent + 40;
        while (items_sent < target)
            send_random_sequence();
        wait_for_drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_in = 8'h00;
        hold_request = 1'b0;
        seq_value = '0;
        seq_len = '0;
        seq_seen = '0;
        mismatches = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200, 21, 64);
        test_random(200, 64, 21);
        test_random(200, 0, 0);
        test_backpressure();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_queue.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_stream_decoder_top.sv
tb/utf8_stream_decoder_top_test.sv
